// ===== design/pqsi_pkg.sv =====
package pqsi_pkg;

	localparam int PRIO_W   = 16;
	localparam int ELEM_IO_W = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

// ===== design/priority_queue_sorted_insert_core.sv =====
// Bounded priority queue built as a row of CAPACITY cells, cell 0 holding the
// head. Each input item is an enqueue, a dequeue or a peek (op in s_tuser) and
// produces exactly one result item with the head element and priority (zero
// when empty), the fill count, an empty flag and a status (dequeue on empty or
// enqueue on full is dropped and flagged). Higher priority leaves first; equal
// priorities leave in arrival order. Every cell compares its priority with the
// incoming one in the same cycle and either holds, takes its left neighbor or
// takes the new item, or shifts toward the head on dequeue; one item per clock
// is accepted while the result register is free or being drained. The result
// register sits between the two sides, so a stalled master costs at most the
// item in flight.
module priority_queue_sorted_insert_core #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // elem[31:0], prio[47:32]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // head_elem[31:0], head_prio[47:32], count[52:48],
	                              // empty_res[53], status[55:54]
);

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int PW     = pqsi_pkg::PRIO_W;

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_d;
	logic              acc;
	logic              full;
	logic              empty;
	pqsi_pkg::op_t     op;
	pqsi_pkg::status_t status;
	pqsi_pkg::cell_ctrl_t ctrl;

	logic [63:0]           elem_wide;
	logic [ELEM_WIDTH-1:0] new_elem;
	logic [PW-1:0]         new_prio;

	logic [CAPACITY-1:0]   occ;
	logic [CAPACITY-1:0]   keep;
	logic [ELEM_WIDTH-1:0] elem_q [CAPACITY];
	logic [PW-1:0]         prio_q [CAPACITY];
	logic [ELEM_WIDTH-1:0] elem_d [CAPACITY];
	logic [PW-1:0]         prio_d [CAPACITY];

	logic [63:0]                         head_wide;
	logic [pqsi_pkg::ELEM_IO_W-1:0]      head_elem_d;
	logic [PW-1:0]                       head_prio_d;

	logic                                out_valid_q;
	logic [pqsi_pkg::ELEM_IO_W-1:0]      head_elem_q;
	logic [PW-1:0]                       head_prio_q;
	logic [pqsi_pkg::COUNT_W-1:0]        count_q;
	logic                                empty_q;
	pqsi_pkg::status_t                   status_q;

	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign op       = pqsi_pkg::op_t'(s_tuser);
	assign full     = (fill_q == FILL_W'(CAPACITY));
	assign empty    = (fill_q == '0);

	assign elem_wide = {32'b0, s_tdata[31:0]};
	assign new_elem  = elem_wide[ELEM_WIDTH-1:0];
	assign new_prio  = s_tdata[47:32];

	always_comb begin
		ctrl   = '0;
		status = pqsi_pkg::ST_OK;
		fill_d = fill_q;
		unique case (op)
			pqsi_pkg::OP_ENQ: begin
				if (full) begin
					status = pqsi_pkg::ST_FULL;
				end else begin
					ctrl.ins = acc;
					fill_d   = fill_q + 1'b1;
				end
			end
			pqsi_pkg::OP_DEQ: begin
				if (empty) begin
					status = pqsi_pkg::ST_EMPTY;
				end else begin
					ctrl.rem = acc;
					fill_d   = fill_q - 1'b1;
				end
			end
			default: begin
				// peek, and the unused code behaves the same
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (FILL_W'(i) < fill_q);

		if (i == 0) begin : g_first
			pqsi_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ[i]),
				.new_elem  (new_elem),
				.new_prio  (new_prio),
				.left_keep (1'b0),
				.left_elem (new_elem),
				.left_prio (new_prio),
				.right_elem(elem_q[(i+1) % CAPACITY]),
				.right_prio(prio_q[(i+1) % CAPACITY]),
				.keep      (keep[i]),
				.elem_q    (elem_q[i]),
				.prio_q    (prio_q[i]),
				.elem_d    (elem_d[i]),
				.prio_d    (prio_d[i])
			);
		end else if (i == CAPACITY - 1) begin : g_last
			pqsi_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ[i]),
				.new_elem  (new_elem),
				.new_prio  (new_prio),
				.left_keep (keep[i-1]),
				.left_elem (elem_q[i-1]),
				.left_prio (prio_q[i-1]),
				.right_elem(elem_q[i]),
				.right_prio(prio_q[i]),
				.keep      (keep[i]),
				.elem_q    (elem_q[i]),
				.prio_q    (prio_q[i]),
				.elem_d    (elem_d[i]),
				.prio_d    (prio_d[i])
			);
		end else begin : g_mid
			pqsi_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ[i]),
				.new_elem  (new_elem),
				.new_prio  (new_prio),
				.left_keep (keep[i-1]),
				.left_elem (elem_q[i-1]),
				.left_prio (prio_q[i-1]),
				.right_elem(elem_q[i+1]),
				.right_prio(prio_q[i+1]),
				.keep      (keep[i]),
				.elem_q    (elem_q[i]),
				.prio_q    (prio_q[i]),
				.elem_d    (elem_d[i]),
				.prio_d    (prio_d[i])
			);
		end
	end

	// head after the operation comes straight from cell 0's next value
	assign head_wide   = 64'(elem_d[0]);
	assign head_elem_d = (fill_d != '0) ? head_wide[31:0] : '0;
	assign head_prio_d = (fill_d != '0) ? prio_d[0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			head_elem_q <= head_elem_d;
			head_prio_q <= head_prio_d;
			count_q     <= pqsi_pkg::COUNT_W'(fill_d);
			empty_q     <= (fill_d == '0);
			status_q    <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {status_q, empty_q, count_q, head_prio_q, head_elem_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (op == pqsi_pkg::OP_ENQ) && !full |=> fill_q == $past(fill_q) + 1'b1)
		else $error("enqueue did not grow the queue");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q >= FILL_W'(2)) |-> (prio_q[0] >= prio_q[1]))
		else $error("head cells out of priority order");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (count_q == '0)))
		else $error("empty flag disagrees with count");

	a_drop_status: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (status != pqsi_pkg::ST_OK) |=> fill_q == $past(fill_q))
		else $error("dropped item changed the fill count");

endmodule

// ===== design/pqsi_cell.sv =====
module pqsi_cell #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                          clk,
	input  pqsi_pkg::cell_ctrl_t          ctrl,
	input  logic                          occ,
	input  logic [ELEM_WIDTH-1:0]         new_elem,
	input  logic [pqsi_pkg::PRIO_W-1:0]   new_prio,
	input  logic                          left_keep,
	input  logic [ELEM_WIDTH-1:0]         left_elem,
	input  logic [pqsi_pkg::PRIO_W-1:0]   left_prio,
	input  logic [ELEM_WIDTH-1:0]         right_elem,
	input  logic [pqsi_pkg::PRIO_W-1:0]   right_prio,
	output logic                          keep,
	output logic [ELEM_WIDTH-1:0]         elem_q,
	output logic [pqsi_pkg::PRIO_W-1:0]   prio_q,
	output logic [ELEM_WIDTH-1:0]         elem_d,
	output logic [pqsi_pkg::PRIO_W-1:0]   prio_d
);

	// equal priority stays ahead, so arrival order holds among equals
	assign keep = occ && (prio_q >= new_prio);

	always_comb begin
		elem_d = elem_q;
		prio_d = prio_q;
		if (ctrl.ins && !keep) begin
			// first cell that yields takes the new item, the rest shift back
			if (left_keep) begin
				elem_d = new_elem;
				prio_d = new_prio;
			end else begin
				elem_d = left_elem;
				prio_d = left_prio;
			end
		end else if (ctrl.rem) begin
			elem_d = right_elem;
			prio_d = right_prio;
		end
	end

	always_ff @(posedge clk) begin
		elem_q <= elem_d;
		prio_q <= prio_d;
	end

endmodule
